// ===== rtl/core/nch_pkg.sv =====
// Package for the normalised colour histogram block.
// Holds request codes, register indexes and fixed field widths; no dependencies.
`timescale 1ns / 1ps

package nch_pkg;

  localparam int SAMPLE_W = 8;
  localparam int HEIGHT_W = 10;
  localparam int STEP_W   = $clog2(HEIGHT_W);
  localparam int CHANNELS = 3;

  localparam logic [HEIGHT_W-1:0] BAR_HEIGHT_RST = HEIGHT_W'(200);

  typedef logic [1:0] func_t;
  localparam func_t FUNC_COUNT = 2'd0;
  localparam func_t FUNC_READ  = 2'd1;
  localparam func_t FUNC_CLEAR = 2'd2;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_BAR_HEIGHT = 1'd0;
  localparam reg_idx_t REG_GRAY_MODE  = 1'd1;

endpackage

// ===== rtl/core/normalized_color_histogram.sv =====
// Top level of the normalised colour histogram: three bin RAMs, peak registers,
// multiply and bit-serial divide lanes. Depends on nch_pkg and nch_ram.
`timescale 1ns / 1ps

// One request at a time, taken while busy is low. A count request holds busy
// in ST_COUNT (RAM read, then increment and write back). A read request holds
// busy through ST_MUL (RAM read and multiply by bar height) and ST_DIV (one
// quotient bit per cycle in each channel's divider); the result strobe out_valid
// is high for one cycle, during which the next request may already be taken. The
// receiver cannot stall, so results must be captured in that cycle. A clear
// request, and reset, clear all BINS addresses of the RAMs with busy high.
// Configuration writes are taken at any time but are meant for idle periods.

module normalized_color_histogram
  import nch_pkg::*;
#(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 22
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  func_t               in_func,
  input  logic [SAMPLE_W-1:0] in_blue_sample,
  input  logic [SAMPLE_W-1:0] in_green_sample,
  input  logic [SAMPLE_W-1:0] in_red_sample,
  input  logic [SAMPLE_W-1:0] in_bin_index,
  output logic                out_valid,
  output logic [HEIGHT_W-1:0] out_blue_height,
  output logic [HEIGHT_W-1:0] out_green_height,
  output logic [HEIGHT_W-1:0] out_red_height,
  output logic                out_empty_flag,
  input  logic                cfg_we,
  input  reg_idx_t            cfg_index,
  input  logic [HEIGHT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(BINS);
  localparam int PW = COUNT_BITS + HEIGHT_W;

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_COUNT, ST_MUL, ST_DIV} state_t;

  state_t                                  state_r;
  logic [AW-1:0]                           clr_addr_r;
  logic [CHANNELS-1:0][AW-1:0]             wr_addr_r;
  logic [CHANNELS-1:0]                     cnt_en_r;
  logic                                    idx_ok_r;
  logic [CHANNELS-1:0][COUNT_BITS-1:0]     peak_r;
  logic [CHANNELS-1:0][PW-1:0]             rem_r;
  logic [CHANNELS-1:0][PW-1:0]             dsr_r;
  logic [CHANNELS-1:0][HEIGHT_W-1:0]       q_r;
  logic [STEP_W-1:0]                       step_r;
  logic [HEIGHT_W-1:0]                     bar_height_r;
  logic                                    gray_mode_r;

  logic                                    accept;
  logic [CHANNELS-1:0][SAMPLE_W-1:0]       sample;
  logic [CHANNELS-1:0]                     sample_ok;
  logic [CHANNELS-1:0]                     ram_we;
  logic [CHANNELS-1:0][AW-1:0]             ram_waddr;
  logic [CHANNELS-1:0][AW-1:0]             ram_raddr;
  logic [CHANNELS-1:0][COUNT_BITS-1:0]     ram_wdata;
  logic [CHANNELS-1:0][COUNT_BITS-1:0]     ram_rdata;
  logic [CHANNELS-1:0][COUNT_BITS-1:0]     inc_cnt;
  logic [CHANNELS-1:0][PW-1:0]             rem_nxt;
  logic [CHANNELS-1:0]                     qbit;
  logic [CHANNELS-1:0][HEIGHT_W-1:0]       q_nxt;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign sample = {in_red_sample, in_green_sample, in_blue_sample};

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      sample_ok[c] = (32'(sample[c]) < BINS) && ((c == 0) || !gray_mode_r);
      ram_raddr[c] = (in_func == FUNC_COUNT) ? AW'(sample[c]) : AW'(in_bin_index);
      inc_cnt[c]   = (&ram_rdata[c]) ? ram_rdata[c] : ram_rdata[c] + 1'b1;
      ram_we[c]    = (state_r == ST_CLEAR) || ((state_r == ST_COUNT) && cnt_en_r[c]);
      ram_waddr[c] = (state_r == ST_CLEAR) ? clr_addr_r : wr_addr_r[c];
      ram_wdata[c] = (state_r == ST_CLEAR) ? '0 : inc_cnt[c];
      qbit[c]      = (rem_r[c] >= dsr_r[c]);
      rem_nxt[c]   = qbit[c] ? rem_r[c] - dsr_r[c] : rem_r[c];
      q_nxt[c]     = {q_r[c][HEIGHT_W-2:0], qbit[c]};
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    nch_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(BINS)
    ) u_ram (
      .clk  (clk),
      .we   (ram_we[g]),
      .waddr(ram_waddr[g]),
      .wdata(ram_wdata[g]),
      .raddr(ram_raddr[g]),
      .rdata(ram_rdata[g])
    );
  end

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_BAR_HEIGHT: bar_height_r <= cfg_wdata;
        REG_GRAY_MODE:  gray_mode_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
    case (state_r)
      ST_CLEAR: begin
        peak_r     <= '0;
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(BINS - 1)) begin
          state_r <= ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          wr_addr_r  <= ram_raddr;
          cnt_en_r   <= sample_ok;
          idx_ok_r   <= (32'(in_bin_index) < BINS);
          clr_addr_r <= '0;
          case (in_func)
            FUNC_COUNT: state_r <= ST_COUNT;
            FUNC_READ:  state_r <= ST_MUL;
            FUNC_CLEAR: state_r <= ST_CLEAR;
            default:    state_r <= ST_IDLE;
          endcase
        end
      end
      ST_COUNT: begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (cnt_en_r[c] && (inc_cnt[c] > peak_r[c])) begin
            peak_r[c] <= inc_cnt[c];
          end
        end
        state_r <= ST_IDLE;
      end
      ST_MUL: begin
        for (int c = 0; c < CHANNELS; c++) begin
          rem_r[c] <= idx_ok_r ? PW'(ram_rdata[c]) * PW'(bar_height_r) : '0;
          dsr_r[c] <= PW'(peak_r[c]) << (HEIGHT_W - 1);
        end
        step_r  <= '0;
        state_r <= ST_DIV;
      end
      ST_DIV: begin
        rem_r  <= rem_nxt;
        q_r    <= q_nxt;
        step_r <= step_r + 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
          dsr_r[c] <= dsr_r[c] >> 1;
        end
        if (step_r == STEP_W'(HEIGHT_W - 1)) begin
          out_valid        <= 1'b1;
          out_blue_height  <= (peak_r[0] == '0) ? '0 : q_nxt[0];
          out_green_height <= (gray_mode_r || peak_r[1] == '0) ? '0 : q_nxt[1];
          out_red_height   <= (gray_mode_r || peak_r[2] == '0) ? '0 : q_nxt[2];
          out_empty_flag   <= (peak_r[0] == '0);
          state_r          <= ST_IDLE;
        end
      end
      default: state_r <= ST_IDLE;
    endcase
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      peak_r       <= '0;
      out_valid    <= 1'b0;
      bar_height_r <= BAR_HEIGHT_RST;
      gray_mode_r  <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/nch_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nch_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/nch_checker.sv =====
// Port-level checks for the normalised colour histogram, bound to the top level.
// Depends on nch_pkg.
`timescale 1ns / 1ps

module nch_checker
  import nch_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input func_t               in_func,
  input logic                out_valid,
  input logic [HEIGHT_W-1:0] out_blue_height,
  input logic                out_empty_flag
);

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // a result is only shown once the block is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FUNC_READ || in_func == FUNC_COUNT)) |=> busy)
    else $error("read or count request did not raise busy");

  a_read_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_READ) |=> !out_valid)
    else $error("read result too early");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_flag) |-> (out_blue_height == '0))
    else $error("empty histogram read a non-zero height");

endmodule

bind normalized_color_histogram nch_checker u_nch_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_func        (in_func),
  .out_valid      (out_valid),
  .out_blue_height(out_blue_height),
  .out_empty_flag (out_empty_flag)
);
